### hw/rtl/tpad_pkg.sv
// Shared constants and types for the triac phase-angle dimmer.
package tpad_pkg;

    localparam int CFG_W         = 14;
    localparam int BRIGHT_W      = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int TIME_BITS_DEF = 14;

    localparam logic [BRIGHT_W-1:0] BRIGHT_FULL = 7'd100;

    localparam logic [BRIGHT_W-1:0] RST_BRIGHT   = 7'd0;
    localparam logic                RST_LIGHT_ON = 1'b0;
    localparam logic [CFG_W-1:0]    RST_MIN_DLY  = 14'd100;
    localparam logic [CFG_W-1:0]    RST_MAX_DLY  = 14'd2500;
    localparam logic [CFG_W-1:0]    RST_PULSE    = 14'd800;
    localparam logic [CFG_W-1:0]    RST_LOCKOUT  = 14'd2000;

    // Brightness times delay span, and its divide by 100 as a reciprocal multiply.
    localparam int PROD_W      = BRIGHT_W + CFG_W;
    localparam int RECIP_SHIFT = PROD_W + 7;
    localparam int RECIP_W     = PROD_W + 1;
    localparam int MULQ_W      = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHT   = 3'd0,
        CFG_LIGHT_ON = 3'd1,
        CFG_MIN_DLY  = 3'd2,
        CFG_MAX_DLY  = 3'd3,
        CFG_PULSE    = 3'd4,
        CFG_LOCKOUT  = 3'd5
    } t_cfg_idx;

endpackage

### hw/rtl/triac_phase_angle_dimmer_core.sv
// Triac phase-angle dimmer: zero-cross lockout, fire delay, gate pulse timing.
// Throughput: one word per cycle unless the output stalls; the fire delay
// divide runs in two pipeline stages (span multiply, reciprocal multiply)
// ahead of the timer stage, which registers the result word.
// Reset (synchronous, active low) empties the pipeline, loads the register
// defaults and clears all timers; previous level resets to one.
module triac_phase_angle_dimmer_core #(
    parameter int TIME_BITS = tpad_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_zero_cross_level,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_gate_drive,
    output logic                           o_relay_on,
    output logic                           o_power_led_on,
    output logic                           o_crossing_accepted,
    input  logic                           i_cfg_we,
    input  logic [tpad_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpad_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int W = (TIME_BITS > tpad_pkg::CFG_W) ? TIME_BITS : tpad_pkg::CFG_W;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    // configuration registers
    logic [tpad_pkg::BRIGHT_W-1:0] r_bright;
    logic                          r_light_on;
    logic [tpad_pkg::CFG_W-1:0]    r_min_dly;
    logic [tpad_pkg::CFG_W-1:0]    r_max_dly;
    logic [tpad_pkg::CFG_W-1:0]    r_pulse_w;
    logic [tpad_pkg::CFG_W-1:0]    r_lockout;

    // pipeline
    logic                          r_v1, r_v2, r_v3;
    logic                          r_lvl1, r_lvl2;
    logic [tpad_pkg::PROD_W-1:0]   r_prod1;
    logic [tpad_pkg::CFG_W-1:0]    r_delay2;
    logic                          w_rdy1, w_rdy2, w_rdy3;

    // timer state
    logic                 r_prev, n_prev;
    logic [TIME_BITS-1:0] r_tsc, n_tsc;
    logic [TIME_BITS-1:0] r_delay, n_delay;
    logic                 r_armed, n_armed;
    logic [TIME_BITS-1:0] r_pulse, n_pulse;

    // result register
    logic r_gate, r_relay, r_led, r_cross;

    logic                          w_enabled;
    logic                          w_accepted;
    logic [tpad_pkg::BRIGHT_W-1:0] w_bright_cl;
    logic [tpad_pkg::CFG_W-1:0]    w_span;
    logic [tpad_pkg::MULQ_W-1:0]   w_mulq;
    logic [tpad_pkg::CFG_W-1:0]    w_quot;
    logic [TIME_BITS-1:0]          w_tsc_inc;

    function automatic logic [TIME_BITS-1:0] f_sat(input logic [tpad_pkg::CFG_W-1:0] v);
        logic [W-1:0] vx;
        vx = W'(v);
        if (vx > W'(TMAX)) begin
            return TMAX;
        end
        return vx[TIME_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright   <= tpad_pkg::RST_BRIGHT;
            r_light_on <= tpad_pkg::RST_LIGHT_ON;
            r_min_dly  <= tpad_pkg::RST_MIN_DLY;
            r_max_dly  <= tpad_pkg::RST_MAX_DLY;
            r_pulse_w  <= tpad_pkg::RST_PULSE;
            r_lockout  <= tpad_pkg::RST_LOCKOUT;
        end else if (i_cfg_we) begin
            unique case (tpad_pkg::t_cfg_idx'(i_cfg_idx))
                tpad_pkg::CFG_BRIGHT:   r_bright   <= i_cfg_data[tpad_pkg::BRIGHT_W-1:0];
                tpad_pkg::CFG_LIGHT_ON: r_light_on <= i_cfg_data[0];
                tpad_pkg::CFG_MIN_DLY:  r_min_dly  <= i_cfg_data;
                tpad_pkg::CFG_MAX_DLY:  r_max_dly  <= i_cfg_data;
                tpad_pkg::CFG_PULSE:    r_pulse_w  <= i_cfg_data;
                tpad_pkg::CFG_LOCKOUT:  r_lockout  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stages move forward independently so bubbles collapse
    assign w_rdy3     = !r_v3 || !i_out_stall;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_stall = !w_rdy1;

    // stage 1: brightness times delay span
    assign w_bright_cl = (r_bright > tpad_pkg::BRIGHT_FULL) ? tpad_pkg::BRIGHT_FULL : r_bright;
    assign w_span      = r_max_dly - r_min_dly;

    // stage 2: divide by 100 through the reciprocal, then pick the delay
    assign w_mulq = tpad_pkg::MULQ_W'(r_prod1) * tpad_pkg::MULQ_W'(tpad_pkg::RECIP_M);
    assign w_quot = w_mulq[tpad_pkg::RECIP_SHIFT +: tpad_pkg::CFG_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_lvl1  <= i_zero_cross_level;
            r_prod1 <= tpad_pkg::PROD_W'(w_bright_cl) * tpad_pkg::PROD_W'(w_span);
        end
        if (w_rdy2) begin
            r_lvl2   <= r_lvl1;
            r_delay2 <= (r_max_dly < r_min_dly) ? r_min_dly : (r_max_dly - w_quot);
        end
        if (w_rdy3) begin
            r_gate  <= n_pulse != '0;
            r_relay <= w_enabled;
            r_led   <= r_light_on;
            r_cross <= w_accepted;
        end
    end

    // stage 3: timers
    assign w_enabled = r_light_on && (r_bright != '0);
    assign w_tsc_inc = (r_tsc == TMAX) ? r_tsc : (r_tsc + 1'b1);
    assign w_accepted = r_prev && !r_lvl2 && (w_tsc_inc >= f_sat(r_lockout));

    always_comb begin
        n_prev  = r_lvl2;
        n_tsc   = w_accepted ? '0 : w_tsc_inc;
        n_delay = r_delay;
        n_armed = r_armed;
        n_pulse = r_pulse;
        if (!w_enabled) begin
            n_delay = '0;
            n_armed = 1'b0;
            n_pulse = '0;
        end else begin
            if (r_pulse != '0) begin
                n_pulse = r_pulse - 1'b1;
            end
            if (r_armed && (r_delay != '0)) begin
                n_delay = r_delay - 1'b1;
            end
            // a crossing restarts the delay even while one is running
            if (w_accepted) begin
                n_delay = f_sat(r_delay2);
                n_armed = 1'b1;
            end
            if (n_armed && (n_delay == '0)) begin
                n_armed = 1'b0;
                n_pulse = f_sat(r_pulse_w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b1;
            r_tsc   <= '0;
            r_delay <= '0;
            r_armed <= 1'b0;
            r_pulse <= '0;
        end else if (r_v2 && w_rdy3) begin
            r_prev  <= n_prev;
            r_tsc   <= n_tsc;
            r_delay <= n_delay;
            r_armed <= n_armed;
            r_pulse <= n_pulse;
        end
    end

    assign o_out_valid         = r_v3;
    assign o_gate_drive        = r_gate;
    assign o_relay_on          = r_relay;
    assign o_power_led_on      = r_led;
    assign o_crossing_accepted = r_cross;

    a_gate_needs_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gate_drive) |-> o_relay_on)
        else $error("gate driven while firing disabled");

    a_disable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_rdy3 && !w_enabled) |=> (r_pulse == '0 && !r_armed && r_delay == '0))
        else $error("timers not cleared while disabled");

    a_cross_restarts_lockout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_rdy3 && w_accepted) |=> (r_tsc == '0))
        else $error("lockout timer not restarted on accepted crossing");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a free pipeline stage");

endmodule
